// File: rtl/core/fbd_pkg.sv
package fbd_pkg;

	// Stream constants.
	localparam logic [7:0]  START_CODE       = 8'd111;
	localparam logic [15:0] NAME_LEN_POS     = 16'd1;
	localparam logic [15:0] LEN_FIRST_POS    = 16'd2;
	localparam logic [15:0] HDR_LAST_POS     = 16'd5;
	localparam logic [15:0] BLOCK_SIZE_RESET = 16'd100;

	// Parser modes; codes 6 and 7 are unused.
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_DISCARD = 3'd1,
		MODE_HDR     = 3'd2,
		MODE_NAME    = 3'd3,
		MODE_PAYLOAD = 3'd4,
		MODE_PAD     = 3'd5
	} mode_t;

	// Classification of one byte.
	typedef enum logic [1:0] {
		KIND_DROP    = 2'd0,
		KIND_HDR     = 2'd1,
		KIND_NAME    = 2'd2,
		KIND_PAYLOAD = 2'd3
	} kind_t;

	// One classified result item.
	typedef struct packed {
		logic [7:0]  out_byte;
		kind_t       byte_kind;
		logic        file_last;
		logic        block_end;
		logic [31:0] payload_left;
	} res_t;

endpackage

// File: rtl/core/fbd_if.sv
// Input channel: one stream byte per item.
interface fbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// Result channel: one classified byte per item.
interface fbd_out_if;
	logic             valid;
	logic             ready;
	logic [7:0]       out_byte;
	fbd_pkg::kind_t   byte_kind;
	logic             file_last;
	logic             block_end;
	logic [31:0]      payload_left;

	modport source (output valid, output out_byte, output byte_kind, output file_last,
		output block_end, output payload_left, input ready);
	modport sink (input valid, input out_byte, input byte_kind, input file_last,
		input block_end, input payload_left, output ready);
endinterface

// File: rtl/core/fbd_parser.sv
module fbd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step_en,
	input  logic [7:0]    data_byte,
	input  logic [15:0]   block_size,
	output fbd_pkg::res_t res
);
	import fbd_pkg::*;

	logic [15:0] pos_q;
	mode_t       mode_q;
	logic [7:0]  name_len_q;
	logic [31:0] remain_q;

	logic [15:0] pos_d;
	mode_t       mode_d;
	logic [7:0]  name_len_d;
	logic [31:0] remain_d;
	logic [15:0] last_pos;
	logic        blk_end;
	kind_t       kind;
	logic        flast;

	// Classify the byte and work out the parser state after it.
	always_comb begin
		last_pos   = (block_size != 16'd0) ? (block_size - 16'd1) : 16'd0;
		blk_end    = (pos_q >= last_pos);
		mode_d     = mode_q;
		name_len_d = name_len_q;
		remain_d   = remain_q;
		kind       = KIND_DROP;
		flast      = 1'b0;

		case (mode_q)
			MODE_IDLE: begin
				if (data_byte == START_CODE) begin
					kind       = KIND_HDR;
					mode_d     = MODE_HDR;
					remain_d   = 32'd0;
					name_len_d = 8'd0;
				end else begin
					mode_d = MODE_DISCARD;
				end
			end
			MODE_HDR: begin
				kind = KIND_HDR;
				// Length field arrives least significant byte first.
				case (pos_q)
					NAME_LEN_POS:           name_len_d = data_byte;
					LEN_FIRST_POS:          remain_d[7:0]   = remain_q[7:0] | data_byte;
					LEN_FIRST_POS + 16'd1:  remain_d[15:8]  = remain_q[15:8] | data_byte;
					LEN_FIRST_POS + 16'd2:  remain_d[23:16] = remain_q[23:16] | data_byte;
					LEN_FIRST_POS + 16'd3:  remain_d[31:24] = remain_q[31:24] | data_byte;
					default: ;
				endcase
				if (pos_q >= HDR_LAST_POS) begin
					if (name_len_d != 8'd0) begin
						mode_d = MODE_NAME;
					end else begin
						mode_d = (remain_d != 32'd0) ? MODE_PAYLOAD : MODE_PAD;
					end
				end
			end
			MODE_NAME: begin
				kind = KIND_NAME;
				if (name_len_q != 8'd0) begin
					name_len_d = name_len_q - 8'd1;
				end
				if (name_len_d == 8'd0) begin
					mode_d = (remain_q != 32'd0) ? MODE_PAYLOAD : MODE_PAD;
				end
			end
			MODE_PAYLOAD: begin
				kind = KIND_PAYLOAD;
				if (remain_q != 32'd0) begin
					remain_d = remain_q - 32'd1;
				end
				if (remain_d == 32'd0) begin
					flast  = 1'b1;
					mode_d = MODE_PAD;
				end
			end
			default: ;
		endcase

		// Block boundary: header or name cut short, padding and discard end here.
		if (blk_end) begin
			pos_d = 16'd0;
			if (mode_d == MODE_HDR || mode_d == MODE_NAME) begin
				name_len_d = 8'd0;
				mode_d     = (remain_d != 32'd0) ? MODE_PAYLOAD : MODE_IDLE;
			end else if (mode_d != MODE_PAYLOAD) begin
				mode_d = MODE_IDLE;
			end
		end else begin
			pos_d = pos_q + 16'd1;
		end

		res.out_byte     = data_byte;
		res.byte_kind    = kind;
		res.file_last    = flast;
		res.block_end    = blk_end;
		res.payload_left = remain_d;
	end

	// Parser state advances once per consumed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 16'd0;
			mode_q     <= MODE_IDLE;
			name_len_q <= 8'd0;
			remain_q   <= 32'd0;
		end else if (step_en) begin
			pos_q      <= pos_d;
			mode_q     <= mode_d;
			name_len_q <= name_len_d;
			remain_q   <= remain_d;
		end
	end

endmodule

// File: rtl/core/fixed_block_file_deframer.sv
// Channel   Dir   Signals                                              Item
// stream    in    valid, ready, data_byte                              one stream byte
// result    out   valid, ready, out_byte, byte_kind, file_last,        one classified byte
//                 block_end, payload_left
// cfg       in    cfg_we, cfg_wdata                                    block size write
//
// Throughput is one item per cycle while the result channel is not stalled.
// The byte is registered at the input, classified by the parser in one pass, and
// the result is registered at the output; the parser state loop closes in the parser.
// A stalled result holds the output register while the input register still takes
// one more item. Reset clears the parser state and sets the block size to 100.
module fixed_block_file_deframer (
	input  logic          clk,
	input  logic          arst_n,
	fbd_in_if.sink        stream,
	fbd_out_if.source     result,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);
	import fbd_pkg::*;

	logic [15:0] block_size_q;
	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        valid_s2;
	res_t        res_s2;
	res_t        res_c;
	logic        s2_free;
	logic        advance;

	// Handshake between the stages.
	assign s2_free      = !valid_s2 || result.ready;
	assign advance      = valid_s1 && s2_free;
	assign stream.ready = !valid_s1 || advance;

	// Block size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BLOCK_SIZE_RESET;
		end else if (cfg_we) begin
			block_size_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			data_byte_s1 <= stream.data_byte;
		end
	end

	fbd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.data_byte  (data_byte_s1),
		.block_size (block_size_q),
		.res        (res_c)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	assign result.valid        = valid_s2;
	assign result.out_byte     = res_s2.out_byte;
	assign result.byte_kind    = res_s2.byte_kind;
	assign result.file_last    = res_s2.file_last;
	assign result.block_end    = res_s2.block_end;
	assign result.payload_left = res_s2.payload_left;

endmodule
